// ===== src/eksm_pkg.sv =====
// ----------------------------------------------------------------------------
// eksm_pkg
// Types, constants and the double-precision helper functions shared by the
// compensated sum/mean blocks.
// ----------------------------------------------------------------------------
package eksm_pkg;

    localparam logic [63:0] QNAN_BITS = 64'h7FF8000000000000;
    localparam logic [63:0] POS_ZERO  = 64'h0000000000000000;

    localparam logic REG_MODE      = 1'b0;
    localparam logic REG_MIN_COUNT = 1'b1;

    // Work item handed from the front to the back through the queue.
    typedef struct packed {
        logic [63:0] sample;
        logic        finite;
        logic        last;
    } eksm_item_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_ADD_Y,
        BK_ADD_T,
        BK_ADD_D,
        BK_ADD_C,
        BK_DIV,
        BK_OUT
    } bk_state_t;

    typedef struct packed {
        logic        sign;
        logic [10:0] exp;
        logic [52:0] man;
    } unp_t;

    function automatic logic is_finite(input logic [63:0] b);
        is_finite = (b[62:52] != 11'h7FF);
    endfunction

endpackage

// ===== src/eksm_fadd.sv =====
// ----------------------------------------------------------------------------
// eksm_fadd
// Double-precision adder, round to nearest even, three stages.
// Stage 1 aligns, stage 2 adds, stage 3 normalizes and rounds.
// ----------------------------------------------------------------------------
module eksm_fadd (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] sum
);
    import eksm_pkg::*;

    logic [2:0]  vld_reg;
    // stage 1
    logic        s1_special_reg;
    logic [63:0] s1_spec_val_reg;
    logic        s1_sa_reg, s1_sb_reg;
    logic [11:0] s1_exp_reg;
    logic [56:0] s1_ma_reg, s1_mb_reg;
    logic        s1_bothzero_sign_reg;
    // stage 2
    logic        s2_special_reg;
    logic [63:0] s2_spec_val_reg;
    logic        s2_sign_reg;
    logic [11:0] s2_exp_reg;
    logic [57:0] s2_mag_reg;
    logic        s2_zsign_reg;
    // stage 3
    logic [63:0] sum_reg;

    logic [10:0] ea, eb;
    logic [52:0] fa, fb;
    logic        a_nan, b_nan, a_inf, b_inf;
    logic        swap;
    logic [10:0] eh, el;
    logic [52:0] fh, fl;
    logic        sh, sl;
    logic [11:0] shamt;
    logic [111:0] lwide;
    logic [56:0] lal;
    logic        sticky;
    logic        spec;
    logic [63:0] spec_val;

    always_comb
    begin
        ea = (a[62:52] == 11'd0) ? 11'd1 : a[62:52];
        eb = (b[62:52] == 11'd0) ? 11'd1 : b[62:52];
        fa = {(a[62:52] != 11'd0), a[51:0]};
        fb = {(b[62:52] != 11'd0), b[51:0]};
        a_nan = (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
        b_nan = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
        a_inf = (a[62:52] == 11'h7FF) && (a[51:0] == 52'd0);
        b_inf = (b[62:52] == 11'h7FF) && (b[51:0] == 52'd0);
        spec = a_nan || b_nan || a_inf || b_inf;
        priority if (a_nan || b_nan || (a_inf && b_inf && (a[63] != b[63])))
            spec_val = QNAN_BITS;
        else if (a_inf)
            spec_val = a;
        else
            spec_val = b;
        swap = {eb, fb} > {ea, fa};
        eh = swap ? eb : ea;
        el = swap ? ea : eb;
        fh = swap ? fb : fa;
        fl = swap ? fa : fb;
        sh = swap ? b[63] : a[63];
        sl = swap ? a[63] : b[63];
        shamt = {1'b0, eh - el};
        lwide = {fl, 3'b000, 56'd0} >> ((shamt > 12'd58) ? 12'd58 : shamt);
        sticky = (lwide[55:0] != 56'd0);
        lal = {lwide[111:56], sticky};
    end

    logic [57:0] add_mag;
    always_comb
    begin
        if (s1_sa_reg == s1_sb_reg)
            add_mag = {1'b0, s1_ma_reg} + {1'b0, s1_mb_reg};
        else
            add_mag = {1'b0, s1_ma_reg} - {1'b0, s1_mb_reg};
    end

    // Normalize and round.
    logic [5:0]  lz;
    logic [57:0] nm;
    logic [12:0] ne;
    logic [63:0] rnd_val;
    logic [53:0] mr;
    logic        g, st;
    logic [12:0] ee;
    logic [58:0] shifted;
    always_comb
    begin
        lz = 6'd0;
        for (int i = 0; i < 58; i++)
        begin
            if (s2_mag_reg[i])
                lz = 6'(57 - i);
        end
        nm = 58'd0;
        ne = 13'd0;
        rnd_val = 64'd0;
        mr = 54'd0;
        g = 1'b0;
        st = 1'b0;
        ee = 13'd0;
        shifted = 59'd0;
        if (s2_mag_reg == 58'd0)
        begin
            rnd_val = {s2_zsign_reg, 63'd0};
        end
        else
        begin
            // value = mag * 2^(exp - 1075 - 3); leading bit target at bit 57
            ee = {1'b0, s2_exp_reg} + 13'd2 - {7'd0, lz};
            if ($signed(ee) < $signed(13'd1))
            begin
                // subnormal: shift less
                shifted = {s2_mag_reg, 1'b0} << (s2_exp_reg[5:0]);
                nm = shifted[57:0];
                ne = 13'd0;
            end
            else
            begin
                nm = s2_mag_reg << lz;
                ne = ee;
            end
            // nm[57] leading, keep 53 bits [57:5], guard [4], sticky [3:0]
            g = nm[4];
            st = (nm[3:0] != 4'd0);
            mr = {1'b0, nm[57:5]} + {53'd0, (g && (st || nm[5]))};
            if (mr[53])
            begin
                mr = mr >> 1;
                ne = ne + 13'd1;
            end
            if ((ne == 13'd0) && mr[52])
                ne = 13'd1;
            if (ne >= 13'd2047)
                rnd_val = {s2_sign_reg, 11'h7FF, 52'd0};
            else
                rnd_val = {s2_sign_reg, ne[10:0], mr[51:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 3'd0;
        else
            vld_reg <= {vld_reg[1:0], start};
    end

    always_ff @(posedge clk)
    begin
        s1_special_reg  <= spec;
        s1_spec_val_reg <= spec_val;
        s1_sa_reg <= sh;
        s1_sb_reg <= sl;
        s1_exp_reg <= {1'b0, eh};
        s1_ma_reg <= {1'b0, fh, 3'b000};
        s1_mb_reg <= {1'b0, lal[56:1]} | {56'd0, lal[0]};
        s1_bothzero_sign_reg <= a[63] & b[63];
        s2_special_reg  <= s1_special_reg;
        s2_spec_val_reg <= s1_spec_val_reg;
        s2_sign_reg <= s1_sa_reg;
        s2_exp_reg  <= s1_exp_reg;
        s2_mag_reg  <= add_mag;
        s2_zsign_reg <= (s1_sa_reg == s1_sb_reg) ? s1_bothzero_sign_reg : 1'b0;
        sum_reg <= s2_special_reg ? s2_spec_val_reg : rnd_val;
    end

    assign done = vld_reg[2];
    assign sum  = sum_reg;
endmodule

// ===== src/eksm_fdiv.sv =====
// ----------------------------------------------------------------------------
// eksm_fdiv
// Double divider by a positive integer-valued double, restoring, one
// quotient bit per cycle, round to nearest even.
// ----------------------------------------------------------------------------
module eksm_fdiv (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] d,
    output logic        done,
    output logic [63:0] quo
);
    import eksm_pkg::*;

    logic        busy_reg;
    logic [5:0]  cnt_reg;
    logic [55:0] rem_reg;
    logic [54:0] dv_reg;
    logic [56:0] q_reg;
    logic        sign_reg;
    logic [12:0] exp_reg;
    logic        spec_reg;
    logic [63:0] spec_val_reg;
    logic        done_reg;
    logic [63:0] quo_reg;

    // Normalize dividend mantissa (subnormals included).
    logic [52:0] fa;
    logic [5:0]  lz;
    logic [52:0] fan;
    logic [12:0] ea;
    always_comb
    begin
        fa = {(a[62:52] != 11'd0), a[51:0]};
        lz = 6'd0;
        for (int i = 0; i < 53; i++)
        begin
            if (fa[i])
                lz = 6'(52 - i);
        end
        fan = fa << lz;
        ea = ((a[62:52] == 11'd0) ? 13'd1 : {2'd0, a[62:52]}) - {7'd0, lz};
    end

    logic [55:0] trial;
    logic [55:0] rem_sh;
    always_comb
    begin
        rem_sh = {rem_reg[54:0], 1'b0};
        trial = rem_sh - {1'b0, dv_reg};
    end

    // Final rounding
    logic [12:0] qe;
    logic [55:0] qm;
    logic [53:0] mr;
    logic [63:0] rv;
    logic        sticky;
    logic [6:0]  rs;
    logic [56:0] qsh;
    always_comb
    begin
        sticky = (rem_reg != 56'd0);
        qm = q_reg[56] ? q_reg[56:1] : q_reg[55:0];
        qe = q_reg[56] ? exp_reg : exp_reg - 13'd1;
        rs = 7'd0;
        qsh = {qm, 1'b0};
        if ($signed(qe) < $signed(13'd1))
        begin
            rs = (($signed(13'd1) - $signed(qe)) > 13'sd56) ? 7'd56 : 7'(13'd1 - qe);
            qsh = {qm, 1'b0} >> rs;
            sticky = sticky || ((({qm, 1'b0} << (7'd57 - rs)) & 57'h1FFFFFFFFFFFFFF) != 57'd0)
                || (q_reg[56] && q_reg[0]);
            qe = 13'd0;
        end
        else
        begin
            sticky = sticky || (q_reg[56] && q_reg[0]);
        end
        // qsh[56:4] mantissa 53 bits, qsh[3] guard, rest sticky
        mr = {1'b0, qsh[56:4]} + {53'd0,
            (qsh[3] && (sticky || (qsh[2:1] != 2'd0) || qsh[4]))};
        if (mr[53])
        begin
            mr = mr >> 1;
            qe = qe + 13'd1;
        end
        if ((qe == 13'd0) && mr[52])
            qe = 13'd1;
        if ($signed(qe) >= $signed(13'd2047))
            rv = {sign_reg, 11'h7FF, 52'd0};
        else
            rv = {sign_reg, qe[10:0], mr[51:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd0;
            end
            else if (busy_reg)
            begin
                if (spec_reg || (cnt_reg == 6'd57))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                    cnt_reg <= cnt_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sign_reg <= a[63];
            spec_reg <= (a[62:52] == 11'h7FF) || ((a[62:0]) == 63'd0);
            spec_val_reg <= a;
            exp_reg <= ea - {2'd0, d[62:52]} + 13'd1023;
            rem_reg <= {3'd0, fan};
            dv_reg  <= {2'd0, 1'b1, d[51:0]};
            q_reg   <= 57'd0;
        end
        else if (busy_reg && !spec_reg && (cnt_reg != 6'd57))
        begin
            if (cnt_reg == 6'd0)
            begin
                // first bit: compare without shift
                if ({1'b0, rem_reg[54:0]} >= {1'b0, dv_reg})
                begin
                    rem_reg <= rem_reg - {1'b0, dv_reg};
                    q_reg <= {q_reg[55:0], 1'b1};
                end
                else
                    q_reg <= {q_reg[55:0], 1'b0};
            end
            else if (!trial[55])
            begin
                rem_reg <= trial;
                q_reg <= {q_reg[55:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                q_reg <= {q_reg[55:0], 1'b0};
            end
        end
        if (busy_reg && (spec_reg || (cnt_reg == 6'd57)))
            quo_reg <= spec_reg ? spec_val_reg : rv;
    end

    assign done = done_reg;
    assign quo  = quo_reg;
endmodule

// ===== src/eksm_front.sv =====
// ----------------------------------------------------------------------------
// eksm_front
// Accepts samples, classifies them as finite or not and queues them for
// the back end.
// ----------------------------------------------------------------------------
module eksm_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [63:0]          sample,
    input  logic                 last_of_series,
    output logic                 item_vld,
    output eksm_pkg::eksm_item_t item,
    input  logic                 item_take
);
    import eksm_pkg::*;

    eksm_item_t  q_mem [2];
    logic [1:0]  cnt_reg;
    logic        wp_reg, rp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            if (push && !full)
                wp_reg <= ~wp_reg;
            if (item_take && item_vld)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, (push && !full)} - {1'b0, (item_take && item_vld)};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
            q_mem[wp_reg] <= '{sample: sample, finite: is_finite(sample),
                               last: last_of_series};
    end

    assign full     = (cnt_reg == 2'd2);
    assign item_vld = (cnt_reg != 2'd0);
    assign item     = q_mem[rp_reg];
endmodule

// ===== src/eksm_back.sv =====
// ----------------------------------------------------------------------------
// eksm_back
// Runs the Kahan update through a shared adder, optionally divides by the
// count, and holds the result in a two-entry output queue.
// ----------------------------------------------------------------------------
module eksm_back #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_vld,
    input  eksm_pkg::eksm_item_t item,
    output logic                 item_take,
    input  logic                 mode,
    input  logic [31:0]          min_count,
    output logic                 empty,
    input  logic                 pop,
    output logic [63:0]          result,
    output logic                 ready_res,
    output logic                 busy
);
    import eksm_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    bk_state_t state_reg, state_next;
    logic [63:0] sum_reg, comp_reg, y_reg, t_reg;
    logic [COUNT_WIDTH-1:0] cnt_reg;
    eksm_item_t cur_reg;
    logic        rdy_reg;
    logic        issued_reg;

    logic        add_start, add_done;
    logic [63:0] add_a, add_b, add_s;
    logic        div_start, div_done;
    logic [63:0] div_q, cnt_dbl;

    logic [64:0] oq_mem [2];
    logic [1:0]  oq_cnt_reg;
    logic        oq_wp_reg, oq_rp_reg;
    logic        oq_push;
    logic [63:0] oq_val;

    eksm_fadd u_add (.clk(clk), .rst_n(rst_n), .start(add_start), .a(add_a), .b(add_b),
                     .done(add_done), .sum(add_s));
    eksm_fdiv u_div (.clk(clk), .rst_n(rst_n), .start(div_start), .a(sum_reg), .d(cnt_dbl),
                     .done(div_done), .quo(div_q));

    // Count as double; exact for counts up to 2^53, rounded above.
    logic [63:0] cw;
    logic [6:0]  msb;
    logic [63:0] nrm;
    logic [53:0] mr;
    logic [10:0] ex;
    always_comb
    begin
        cw = 64'(cnt_reg);
        msb = 7'd0;
        for (int i = 0; i < 64; i++)
        begin
            if (cw[i])
                msb = 7'(i);
        end
        nrm = cw << (7'd63 - msb);
        mr = {1'b0, nrm[63:11]} + {53'd0, (nrm[10] && ((nrm[9:0] != 10'd0) || nrm[11]))};
        ex = 11'(msb) + 11'd1023;
        if (mr[53])
        begin
            mr = mr >> 1;
            ex = ex + 11'd1;
        end
        cnt_dbl = {1'b0, ex, mr[51:0]};
    end

    always_comb
    begin
        state_next = state_reg;
        add_start = 1'b0;
        add_a = 64'd0;
        add_b = 64'd0;
        div_start = 1'b0;
        item_take = 1'b0;
        oq_push = 1'b0;
        oq_val = sum_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (item_vld && (oq_cnt_reg != 2'd2))
                begin
                    item_take = 1'b1;
                    state_next = item.finite ? BK_ADD_Y : BK_OUT;
                end
            end
            BK_ADD_Y:
            begin
                add_a = cur_reg.sample;
                add_b = {~comp_reg[63], comp_reg[62:0]};
                add_start = !issued_reg;
                if (add_done)
                    state_next = BK_ADD_T;
            end
            BK_ADD_T:
            begin
                add_a = sum_reg;
                add_b = y_reg;
                add_start = !issued_reg;
                if (add_done)
                    state_next = BK_ADD_D;
            end
            BK_ADD_D:
            begin
                add_a = t_reg;
                add_b = {~sum_reg[63], sum_reg[62:0]};
                add_start = !issued_reg;
                if (add_done)
                    state_next = BK_ADD_C;
            end
            BK_ADD_C:
            begin
                add_a = add_s;
                add_b = {~y_reg[63], y_reg[62:0]};
                add_start = !issued_reg;
                if (add_done)
                    state_next = BK_OUT;
            end
            BK_OUT:
            begin
                if (rdy_reg && mode)
                begin
                    div_start = 1'b1;
                    state_next = BK_DIV;
                end
                else
                begin
                    oq_push = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            BK_DIV:
            begin
                oq_val = div_q;
                if (div_done)
                begin
                    oq_push = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
                state_next = BK_IDLE;
        endcase
    end

    // Readiness after this item's count update.
    logic [COUNT_WIDTH-1:0] cnt_new;
    logic [63:0] min_ext;
    assign cnt_new = (cnt_reg != CNT_MAX) ? cnt_reg + 1'b1 : cnt_reg;
    assign min_ext = 64'(min_count);

    logic [63:0] fin_val;
    always_comb
    begin
        fin_val = oq_val;
        if (!rdy_reg)
            fin_val = QNAN_BITS;
        else if ((oq_val[62:52] == 11'h7FF) && (oq_val[51:0] != 52'd0))
            fin_val = QNAN_BITS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            sum_reg <= POS_ZERO;
            comp_reg <= POS_ZERO;
            cnt_reg <= '0;
            issued_reg <= 1'b0;
            rdy_reg <= 1'b0;
            oq_cnt_reg <= 2'd0;
            oq_wp_reg <= 1'b0;
            oq_rp_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (add_start)
                issued_reg <= 1'b1;
            if (add_done)
                issued_reg <= 1'b0;
            if (state_reg == BK_IDLE && item_take)
            begin
                rdy_reg <= (item.finite ? (cnt_new != '0) && (64'(cnt_new) >= min_ext)
                                        : (cnt_reg != '0) && (64'(cnt_reg) >= min_ext));
                if (item.finite)
                    cnt_reg <= cnt_new;
            end
            if (state_reg == BK_ADD_T && add_done)
                t_reg <= add_s;
            if (state_reg == BK_ADD_C && add_done)
            begin
                comp_reg <= add_s;
                sum_reg <= t_reg;
            end
            if (oq_push && cur_reg.last)
            begin
                sum_reg <= POS_ZERO;
                comp_reg <= POS_ZERO;
                cnt_reg <= '0;
            end
            if (oq_push)
                oq_wp_reg <= ~oq_wp_reg;
            if (pop && !empty)
                oq_rp_reg <= ~oq_rp_reg;
            oq_cnt_reg <= oq_cnt_reg + {1'b0, oq_push} - {1'b0, (pop && !empty)};
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
            cur_reg <= item;
        if (state_reg == BK_ADD_Y && add_done)
            y_reg <= add_s;
        if (oq_push)
            oq_mem[oq_wp_reg] <= {rdy_reg, fin_val};
    end

    assign empty     = (oq_cnt_reg == 2'd0);
    assign result    = oq_mem[oq_rp_reg][63:0];
    assign ready_res = oq_mem[oq_rp_reg][64];
    assign busy      = (state_reg != BK_IDLE);
endmodule

// ===== src/expanding_kahan_sum_mean_core.sv =====
// ----------------------------------------------------------------------------
// expanding_kahan_sum_mean_core
// Kahan-compensated running sum or mean of a stream of doubles.
//
//  channel   | handshake            | payload
//  ----------+----------------------+---------------------------
//  input     | push / full          | sample, last_of_series
//  result    | empty / pop          | result, ready_res
//  config    | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// A finite sample runs the back end through take, four dependent passes through
// the three-stage adder and the result write; a non-finite one skips the adds.
// A ready mean adds a divider pass, cut short for a zero or non-finite sum.
// Reset clears the sums, count and config registers. A full result queue stalls
// the back end; the two-entry input queue then fills and raises full.
// ----------------------------------------------------------------------------
module expanding_kahan_sum_mean_core #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [63:0] sample,
    input  logic        last_of_series,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] result,
    output logic        ready_res,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);
    import eksm_pkg::*;

    logic        mode_reg;
    logic [31:0] min_count_reg;
    logic        item_vld, item_take, busy;
    eksm_item_t  item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            min_count_reg <= 32'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MODE:      mode_reg <= cfg_data[0];
                REG_MIN_COUNT: min_count_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    eksm_front u_front (.clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .sample(sample), .last_of_series(last_of_series), .item_vld(item_vld),
        .item(item), .item_take(item_take));

    eksm_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (.clk(clk), .rst_n(rst_n),
        .item_vld(item_vld), .item(item), .item_take(item_take), .mode(mode_reg),
        .min_count(min_count_reg), .empty(empty), .pop(pop), .result(result),
        .ready_res(ready_res), .busy(busy));

    a_nan_canon: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result[62:52] == 11'h7FF) && (result[51:0] != 52'd0))
        |-> (result == QNAN_BITS))
        else $error("non-canonical NaN on result");

    a_not_ready_nan: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !ready_res) |-> (result == QNAN_BITS))
        else $error("not-ready result is not quiet NaN");

    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        item_take |-> !$past(busy) || $past(item_take) == 1'b0)
        else $error("item taken while back end busy");
endmodule
